// ===== sv/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg
// Types, constants and the square root step of the rotated box bounds unit.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int unsigned NUM_SQRT_STAGES = 16;

  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5,
    CFG_MODE  = 3'd6
  } cfg_index_t;

  localparam logic [30:0] SAT31         = 31'h7fffffff;
  localparam logic [34:0] ONE_Q28       = 35'h010000000;
  localparam logic [19:0] FIVE_HUND_Q24 = 20'd838861;

  // one digit-by-digit square root state
  typedef struct packed {
    logic [63:0] op;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // fields that travel beside the square root stages
  typedef struct packed {
    logic [2:0][31:0] center;
    logic [2:0][30:0] half;
    logic             mode;
    logic             huge;
  } side_t;

  function automatic sq_t sqrt_step(sq_t cur);
    logic [35:0] rs;
    logic [35:0] tr;
    sq_t         nx;
    rs = {cur.rem, cur.op[63:62]};
    tr = {2'b00, cur.root, 2'b01};
    nx.op = {cur.op[61:0], 2'b00};
    if (rs >= tr) begin
      nx.rem  = 34'(rs - tr);
      nx.root = {cur.root[30:0], 1'b1};
    end else begin
      nx.rem  = 34'(rs);
      nx.root = {cur.root[30:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

// ===== sv/rotated_box_bounds_unit.sv =====
// ----------------------------------------------------------------------------
// rotated_box_bounds_unit
// World bounds of one object pose: center plus rotated half extents or radius.
// ----------------------------------------------------------------------------
// One pose enters per cycle unless in_stall is raised; the pipeline is four
// arithmetic stages (quaternion products, matrix and scaled half size,
// products, row sums), sixteen square root stages at two root bits each, and
// three stages of rounding, radius scaling and output. Every stage
// holds its item while the next one is full and stalled, so bubbles are
// squeezed out and input transfers continue while a result waits. The
// configuration port is always ready; write it only while the unit is empty.
module rotated_box_bounds_unit
  import rbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] rot_w,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [23:0]        scale_x,
  input  logic [23:0]        scale_y,
  input  logic [23:0]        scale_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic signed [31:0] center_z,
  output logic [30:0]        half_x,
  output logic [30:0]        half_y,
  output logic [30:0]        half_z,
  output logic [30:0]        radius
);

  localparam int unsigned SQ0    = 4;
  localparam int unsigned STAGES = SQ0 + NUM_SQRT_STAGES + 3;
  localparam int unsigned R1     = SQ0 + NUM_SQRT_STAGES;

  // configuration
  logic signed [2:0][31:0] lmin;
  logic signed [2:0][31:0] lmax;
  logic                    bound_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lmin       <= '0;
      lmax       <= '0;
      bound_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_X: lmin[0] <= cfg_data;
        CFG_MIN_Y: lmin[1] <= cfg_data;
        CFG_MIN_Z: lmin[2] <= cfg_data;
        CFG_MAX_X: lmax[0] <= cfg_data;
        CFG_MAX_Y: lmax[1] <= cfg_data;
        CFG_MAX_Z: lmax[2] <= cfg_data;
        CFG_MODE:  bound_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: quaternion products, corner size and center sum
  logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic [2:0][32:0]   s1_dmag;
  logic [2:0][34:0]   s1_csum;
  logic [2:0][23:0]   s1_sc;
  logic               s1_mode;
  logic [2:0][32:0]   dmag_next;
  logic [2:0][34:0]   csum_next;
  logic [2:0][31:0]   pos_all;

  assign pos_all = {pos_z, pos_y, pos_x};

  always_comb begin
    logic signed [32:0] diff;
    for (int j = 0; j < 3; j++) begin
      diff = 33'(signed'(lmax[j])) - 33'(signed'(lmin[j]));
      dmag_next[j] = diff[32] ? 33'(-diff) : 33'(diff);
      csum_next[j] = 35'(signed'(lmin[j])) + 35'(signed'(lmax[j]))
                   + {{2{pos_all[j][31]}}, pos_all[j], 1'b0} + 35'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_xx    <= 32'(rot_x) * 32'(rot_x);
      p_yy    <= 32'(rot_y) * 32'(rot_y);
      p_zz    <= 32'(rot_z) * 32'(rot_z);
      p_xy    <= 32'(rot_x) * 32'(rot_y);
      p_xz    <= 32'(rot_x) * 32'(rot_z);
      p_yz    <= 32'(rot_y) * 32'(rot_z);
      p_wx    <= 32'(rot_w) * 32'(rot_x);
      p_wy    <= 32'(rot_w) * 32'(rot_y);
      p_wz    <= 32'(rot_w) * 32'(rot_z);
      s1_dmag <= dmag_next;
      s1_csum <= csum_next;
      s1_sc   <= {scale_z, scale_y, scale_x};
      s1_mode <= bound_mode;
    end
  end

  // stage 2: matrix magnitudes, scaled half size, scale squares, center saturation
  logic [2:0][2:0][21:0] s2_m;
  logic [2:0][40:0]      s2_e;
  logic [2:0][31:0]      s2_center;
  logic [2:0][47:0]      s2_sq;
  logic                  s2_mode;
  logic [2:0][2:0][21:0] m_next;
  logic [2:0][40:0]      e_next;
  logic [2:0][31:0]      center_next;

  always_comb begin
    logic signed [34:0] r [3][3];
    logic [34:0]        mg;
    logic [56:0]        prod;
    logic signed [33:0] c;
    r[0][0] = signed'(ONE_Q28) - ((35'(p_yy) + 35'(p_zz)) <<< 1);
    r[0][1] = (35'(p_xy) - 35'(p_wz)) <<< 1;
    r[0][2] = (35'(p_xz) + 35'(p_wy)) <<< 1;
    r[1][0] = (35'(p_xy) + 35'(p_wz)) <<< 1;
    r[1][1] = signed'(ONE_Q28) - ((35'(p_xx) + 35'(p_zz)) <<< 1);
    r[1][2] = (35'(p_yz) - 35'(p_wx)) <<< 1;
    r[2][0] = (35'(p_xz) - 35'(p_wy)) <<< 1;
    r[2][1] = (35'(p_yz) + 35'(p_wx)) <<< 1;
    r[2][2] = signed'(ONE_Q28) - ((35'(p_xx) + 35'(p_yy)) <<< 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mg = r[i][j][34] ? 35'(-r[i][j]) : 35'(r[i][j]);
        m_next[i][j] = 22'((36'(mg) + 36'd2048) >> 12);
      end
    end
    for (int j = 0; j < 3; j++) begin
      prod = 57'(s1_dmag[j]) * 57'(s1_sc[j]);
      e_next[j] = 41'((58'(prod) + 58'd65536) >> 17);
      c = 34'(signed'(s1_csum[j]) >>> 1);
      if (c[33:31] == 3'b000 || c[33:31] == 3'b111) begin
        center_next[j] = c[31:0];
      end else if (c[33]) begin
        center_next[j] = 32'h80000000;
      end else begin
        center_next[j] = 32'h7fffffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_m      <= m_next;
      s2_e      <= e_next;
      s2_center <= center_next;
      for (int j = 0; j < 3; j++) begin
        s2_sq[j] <= 48'(s1_sc[j]) * 48'(s1_sc[j]);
      end
      s2_mode   <= s1_mode;
    end
  end

  // stage 3: row products and sphere squares
  logic [2:0][2:0][62:0] s3_pm;
  logic [2:0][61:0]      s3_es;
  logic [49:0]           s3_t;
  logic                  s3_huge;
  logic [2:0][31:0]      s3_center;
  logic                  s3_mode;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_pm[i][j] <= 63'(s2_m[i][j]) * 63'(s2_e[j]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        s3_es[j] <= (|s2_e[j][40:32]) ? 62'd0
                  : 62'((64'(s2_e[j][31:0]) * 64'(s2_e[j][31:0])) >> 2);
      end
      s3_t      <= 50'(s2_sq[0]) + 50'(s2_sq[1]) + 50'(s2_sq[2]);
      s3_huge   <= |{s2_e[0][40:32], s2_e[1][40:32], s2_e[2][40:32]};
      s3_center <= s2_center;
      s3_mode   <= s2_mode;
    end
  end

  // stage 4: row sums, rounding, sphere sum
  logic [2:0][30:0] half_next;

  always_comb begin
    logic [64:0] acc;
    logic [49:0] rnd;
    for (int i = 0; i < 3; i++) begin
      acc = 65'(s3_pm[i][0]) + 65'(s3_pm[i][1]) + 65'(s3_pm[i][2]);
      rnd = 50'((66'(acc) + 66'd32768) >> 16);
      if (s3_mode) begin
        half_next[i] = '0;
      end else if (|rnd[49:31]) begin
        half_next[i] = SAT31;
      end else begin
        half_next[i] = rnd[30:0];
      end
    end
  end

  logic [63:0] s4_s;
  logic [49:0] s4_t;
  side_t       s4_side;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_s           <= 64'(s3_es[0]) + 64'(s3_es[1]) + 64'(s3_es[2]);
      s4_t           <= s3_t;
      s4_side.center <= s3_center;
      s4_side.half   <= half_next;
      s4_side.mode   <= s3_mode;
      s4_side.huge   <= s3_huge;
    end
  end

  // square root stages, two root bits per stage for both operands
  sq_t   sqa [NUM_SQRT_STAGES];
  sq_t   sqb [NUM_SQRT_STAGES];
  side_t sqs [NUM_SQRT_STAGES];

  for (genvar g = 0; g < NUM_SQRT_STAGES; g++) begin : g_sqrt
    sq_t   a_in;
    sq_t   b_in;
    side_t s_in;
    if (g == 0) begin : g_first
      assign a_in = '{op: s4_s, rem: '0, root: '0};
      assign b_in = '{op: 64'(s4_t), rem: '0, root: '0};
      assign s_in = s4_side;
    end else begin : g_rest
      assign a_in = sqa[g-1];
      assign b_in = sqb[g-1];
      assign s_in = sqs[g-1];
    end
    always_ff @(posedge clk) begin
      if (en[SQ0+g]) begin
        sqa[g] <= sqrt_step(sqrt_step(a_in));
        sqb[g] <= sqrt_step(sqrt_step(b_in));
        sqs[g] <= s_in;
      end
    end
  end

  // rounding of both roots
  logic [32:0] r1_a;
  logic [25:0] r1_b;
  side_t       r1_side;
  sq_t         fa;
  sq_t         fb;

  assign fa = sqa[NUM_SQRT_STAGES-1];
  assign fb = sqb[NUM_SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (en[R1]) begin
      r1_a    <= 33'(fa.root) + 33'(34'(fa.rem) > 34'(fa.root));
      r1_b    <= 26'(33'(fb.root) + 33'(34'(fb.rem) > 34'(fb.root)));
      r1_side <= sqs[NUM_SQRT_STAGES-1];
    end
  end

  // scale length times five hundredths
  logic [32:0] r2_a;
  logic [45:0] r2_bp;
  side_t       r2_side;

  always_ff @(posedge clk) begin
    if (en[R1+1]) begin
      r2_a    <= r1_a;
      r2_bp   <= 46'(r1_b) * 46'(FIVE_HUND_Q24);
      r2_side <= r1_side;
    end
  end

  // output register
  logic [33:0] rad;
  logic [30:0] radius_next;

  always_comb begin
    rad = 34'(r2_a) + 34'((47'(r2_bp) + 47'h800000) >> 24);
    if (!r2_side.mode) begin
      radius_next = '0;
    end else if (r2_side.huge || (|rad[33:31])) begin
      radius_next = SAT31;
    end else begin
      radius_next = rad[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      center_x <= r2_side.center[0];
      center_y <= r2_side.center[1];
      center_z <= r2_side.center[2];
      half_x   <= r2_side.half[0];
      half_y   <= r2_side.half[1];
      half_z   <= r2_side.half[2];
      radius   <= radius_next;
    end
  end

endmodule

// ===== sim/rotated_box_bounds_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_box_bounds_unit_tb
// Poses go in through the input channel with random gaps and output stalls;
// every result is checked field by field against a local computation of the
// world center, rotated half extents and sphere radius.
// ----------------------------------------------------------------------------
module rotated_box_bounds_unit_tb;
  import rbb_pkg::*;

  localparam int unsigned PIPE_LATENCY = 23;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic signed [31:0] px, py, pz;
    logic [23:0]        sx, sy, sz;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        hx, hy, hz;
    logic [30:0]        rad;
  } bounds_t;

  typedef struct {
    pose_t   p;
    bit      known;
    bounds_t b;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] rot_w = '0, rot_x = '0, rot_y = '0, rot_z = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [23:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0] half_x, half_y, half_z, radius;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rotated_box_bounds_unit u_top (.*);

  // local copy of the configuration
  logic signed [63:0] box_min [3];
  logic signed [63:0] box_max [3];
  bit sphere_mode;

  bounds_t pending_bounds [$];
  int errors = 0;
  int poses_sent = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root_nearest(logic [63:0] s);
    logic [63:0] r, bit_, n;
    r = 0;
    n = s;
    bit_ = 64'd1 << 62;
    while (bit_ > s) bit_ >>= 2;
    while (bit_ != 0) begin
      if (n >= r + bit_) begin
        n -= r + bit_;
        r = (r >> 1) + bit_;
      end else begin
        r >>= 1;
      end
      bit_ >>= 2;
    end
    if (n > r) r += 1;
    return r;
  endfunction

  function automatic logic [30:0] clip31(logic [63:0] v);
    return v > 64'(SAT31) ? SAT31 : v[30:0];
  endfunction

  function automatic bounds_t world_bounds(pose_t p);
    bounds_t b;
    logic signed [63:0] q [4];
    logic signed [63:0] pos [3];
    logic signed [63:0] rm [3][3];
    logic signed [63:0] v, c, one;
    logic [63:0] sc [3], ext [3], acc, m, s, t, a, bl;
    logic [30:0] hv [3];
    logic signed [31:0] cv [3];
    bit huge;
    q[0] = p.w; q[1] = p.x; q[2] = p.y; q[3] = p.z;
    pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
    sc[0] = p.sx; sc[1] = p.sy; sc[2] = p.sz;
    for (int i = 0; i < 3; i++) begin
      // floor of (sum+1)/2 is round half up
      v = box_min[i] + box_max[i] + 2 * pos[i] + 1;
      c = v >>> 1;
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      cv[i] = c[31:0];
      ext[i] = (abs64(box_max[i] - box_min[i]) * sc[i] + (64'd1 << 16)) >> 17;
    end
    b.cx = cv[0]; b.cy = cv[1]; b.cz = cv[2];
    b.hx = '0; b.hy = '0; b.hz = '0; b.rad = '0;
    if (!sphere_mode) begin
      one = 64'sd1 << 28;
      rm[0][0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
      rm[0][1] = 2 * (q[1] * q[2] - q[0] * q[3]);
      rm[0][2] = 2 * (q[1] * q[3] + q[0] * q[2]);
      rm[1][0] = 2 * (q[1] * q[2] + q[0] * q[3]);
      rm[1][1] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
      rm[1][2] = 2 * (q[2] * q[3] - q[0] * q[1]);
      rm[2][0] = 2 * (q[1] * q[3] - q[0] * q[2]);
      rm[2][1] = 2 * (q[2] * q[3] + q[0] * q[1]);
      rm[2][2] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          m = (abs64(rm[i][j]) + 2048) >> 12;
          acc += m * ext[j];
        end
        hv[i] = clip31((acc + (64'd1 << 15)) >> 16);
      end
      b.hx = hv[0]; b.hy = hv[1]; b.hz = hv[2];
    end else begin
      huge = 0;
      s = 0;
      t = 0;
      for (int i = 0; i < 3; i++) begin
        if (ext[i] > 64'hFFFF_FFFF) huge = 1;
        else s += (ext[i] * ext[i]) >> 2;
        t += sc[i] * sc[i];
      end
      if (huge) begin
        b.rad = SAT31;
      end else begin
        a = root_nearest(s);
        bl = root_nearest(t);
        b.rad = clip31(a + ((bl * 64'(FIVE_HUND_Q24) + (64'd1 << 23)) >> 24));
      end
    end
    return b;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d, %s: got %h expected %h", results_seen, what, got, want);
    errors++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= CFG_MIN_Z) box_min[idx] = signed'(val);
    else if (idx <= CFG_MAX_Z) box_max[idx - CFG_MAX_X] = signed'(val);
    else sphere_mode = val[0];
    @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] mn [3], logic [31:0] mx [3], logic [31:0] mode);
    write_reg(CFG_MIN_X, mn[0]); write_reg(CFG_MIN_Y, mn[1]); write_reg(CFG_MIN_Z, mn[2]);
    write_reg(CFG_MAX_X, mx[0]); write_reg(CFG_MAX_Y, mx[1]); write_reg(CFG_MAX_Z, mx[2]);
    write_reg(CFG_MODE, mode);
  endtask

  // wait for every expected result, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high after a transfer so poses can follow back to back
  task automatic send_pose(pose_t p, bit known, bounds_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {rot_w, rot_x, rot_y, rot_z, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z} <= p;
    in_valid <= 1'b1;
    pending_bounds.push_back(known ? want : world_bounds(p));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    poses_sent++;
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(32768) - 16384);
      default: return 16'($urandom_range(16384) - 8192);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    logic [15:0] qs [4];
    int mag;
    // mostly near-unit quaternions, some arbitrary
    if ($urandom_range(3) != 0) begin
      qs[0] = 16'($urandom_range(16384)); qs[1] = 16'($urandom_range(16384));
      qs[2] = 16'($urandom_range(16384)); qs[3] = 16'($urandom_range(16384));
      mag = $sqrt(real'(qs[0]) ** 2 + real'(qs[1]) ** 2 + real'(qs[2]) ** 2
                  + real'(qs[3]) ** 2) + 1;
      for (int k = 0; k < 4; k++) begin
        qs[k] = 16'((qs[k] * 16384) / mag);
        if ($urandom_range(1)) qs[k] = -qs[k];
      end
      p.w = qs[0]; p.x = qs[1]; p.y = qs[2]; p.z = qs[3];
    end else begin
      p.w = rand_quat(); p.x = rand_quat(); p.y = rand_quat(); p.z = rand_quat();
    end
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    if ($urandom_range(1)) begin
      p.px >>>= 8; p.py >>>= 8; p.pz >>>= 8;
    end
    p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
    if ($urandom_range(3) != 0) begin
      p.sx = 24'($urandom_range(18'h3ffff)); p.sy = 24'($urandom_range(18'h3ffff));
      p.sz = 24'($urandom_range(18'h3ffff));
    end
    return p;
  endfunction

  // result side: stalls and checking
  always @(posedge clk) begin
    bounds_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_bounds.size() == 0) begin
          $display("unexpected result %0d", results_seen);
          errors++;
        end else begin
          want = pending_bounds.pop_front();
          if (center_x !== want.cx) report_mismatch("center_x", center_x, want.cx);
          if (center_y !== want.cy) report_mismatch("center_y", center_y, want.cy);
          if (center_z !== want.cz) report_mismatch("center_z", center_z, want.cz);
          if (half_x !== want.hx) report_mismatch("half_x", half_x, want.hx);
          if (half_y !== want.hy) report_mismatch("half_y", half_y, want.hy);
          if (half_z !== want.hz) report_mismatch("half_z", half_z, want.hz);
          if (radius !== want.rad) report_mismatch("radius", radius, want.rad);
        end
        results_seen++;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t r;
    bounds_t z;
    logic [31:0] mn [3], mx [3];
    int phase_idle [4];
    int phase_stall [4];

    phase_idle = '{0, 61, 0, 28};
    phase_stall = '{0, 0, 61, 28};
    box_min = '{0, 0, 0};
    box_max = '{0, 0, 0};
    sphere_mode = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the box is a point at the origin: center equals position
    z = '0;
    r.known = 1;
    r.p = '{16'sd16384, 0, 0, 0, 32'sd12345, -32'sd7, 32'sh7fffffff, 24'hffffff, 24'd1, 24'd0};
    r.b = z; r.b.cx = 12345; r.b.cy = -7; r.b.cz = 32'sh7fffffff;
    rows.push_back(r);
    foreach (rows[k]) send_pose(rows[k].p, rows[k].known, rows[k].b);
    rows.delete();
    drain();

    // directed: swapped corners, extreme positions and quaternions, box mode
    mn = '{32'sh0002_0000, -32'sh0001_0000, 32'sh7fffffff};
    mx = '{-32'sh0003_0000, 32'sh0004_8000, 32'sh80000000};
    set_box(mn, mx, 0);
    r.known = 0;
    r.p = '{16'sd16384, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 24'h010000, 24'h010000, 24'h010000};
    rows.push_back(r);
    r.p = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 32'sh80000000, 32'sh7fffffff,
            -1, 24'hffffff, 24'hffffff, 24'hffffff};
    rows.push_back(r);
    r.p = '{16'sd11585, 16'sd11585, 0, 0, 0, 0, 0, 24'h008000, 24'h020000, 24'h000001};
    rows.push_back(r);
    r.p = '{0, 0, 0, 16'sd16384, 1, -1, 32'sh40000000, 24'h000000, 24'h800000, 24'h7fffff};
    rows.push_back(r);
    r.p = '{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 5, 6, 7, 24'h123456, 24'h010000, 24'h0};
    rows.push_back(r);
    foreach (rows[k]) send_pose(rows[k].p, 0, z);
    drain();
    // same poses as spheres, big box makes the radius saturate
    write_reg(CFG_MODE, 32'hffff_fffe);
    write_reg(CFG_MODE, 32'h0000_0003);
    foreach (rows[k]) send_pose(rows[k].p, 0, z);
    drain();
    mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    mx = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    set_box(mn, mx, 1);
    r.p = '{16'sd16384, 0, 0, 0, 0, 0, 0, 24'hffffff, 24'hffffff, 24'hffffff};
    r.b = z; r.b.rad = SAT31;
    r.b.cx = 0; r.b.cy = 0; r.b.cz = 0;
    send_pose(r.p, 1, r.b);
    foreach (rows[k]) send_pose(rows[k].p, 0, z);
    drain();

    // random part: eight phases cycling through four idle and stall settings, fresh configuration per phase
    for (int ph = 0; ph < 8; ph++) begin
      sender_idle_pct = phase_idle[ph % 4];
      stall_pct = phase_stall[ph % 4];
      for (int k = 0; k < 3; k++) begin
        mn[k] = (ph == 7) ? $urandom : 32'($urandom_range(32'h00ff_ffff)) - 32'h0080_0000;
        mx[k] = (ph == 7) ? $urandom : 32'($urandom_range(32'h00ff_ffff)) - 32'h0080_0000;
      end
      set_box(mn, mx, ph % 2);
      if (ph == 2) begin
        // long output hold-off while poses keep coming
        hold_cycles = 60;
        for (int k = 0; k < 40; k++) send_pose(rand_pose(), 0, z);
      end
      for (int k = 0; k < 62; k++) send_pose(rand_pose(), 0, z);
      drain();
    end

    $display("%0d poses sent, %0d results checked, box and sphere modes,", poses_sent,
             results_seen);
    $display("extreme corners, scales and quaternions under random gaps and stalls");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
